@@ hw/rtl/rk4_pkg.sv @@
package rk4_pkg;

    localparam int NUM_EQ   = 4;
    localparam int RF_DEPTH = 20;
    localparam int RF_AW    = 5;
    localparam int PROG_LEN = 128;
    localparam int PC_W     = 7;

    localparam logic [24:0] STEP_RESET = 25'd1678;
    localparam logic        ACT_LOAD   = 1'b0;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_MUL  = 2'd2;
    localparam logic [1:0] OP_DIV6 = 2'd3;

    localparam logic [2:0] SRC_RF   = 3'd0;
    localparam logic [2:0] SRC_ONE  = 3'd1;
    localparam logic [2:0] SRC_QTR  = 3'd2;
    localparam logic [2:0] SRC_H    = 3'd3;
    localparam logic [2:0] SRC_HH   = 3'd4;
    localparam logic [2:0] SRC_ZERO = 3'd5;

    localparam logic [RF_AW-1:0] RA_X = 5'd0;
    localparam logic [RF_AW-1:0] RA_Y = 5'd4;
    localparam logic [RF_AW-1:0] RA_K = 5'd8;
    localparam logic [RF_AW-1:0] RA_S = 5'd12;
    localparam logic [RF_AW-1:0] RA_T = 5'd16;
    localparam logic [RF_AW-1:0] RA_U = 5'd17;
    localparam logic [RF_AW-1:0] RA_P = 5'd18;
    localparam logic [RF_AW-1:0] RA_Q = 5'd19;

    // floor(n / 6) == (n * DIV6_RECIP) >> DIV6_SHIFT for n below 2^33
    localparam logic [31:0] DIV6_RECIP = 32'd2863311531;
    localparam int          DIV6_SHIFT = 34;

    typedef struct packed {
        logic [1:0]       op;
        logic [RF_AW-1:0] dst;
        logic [2:0]       sel_a;
        logic [RF_AW-1:0] ra;
        logic [2:0]       sel_b;
        logic [RF_AW-1:0] rb;
    } instr_t;

    typedef instr_t [PROG_LEN-1:0] prog_t;

    function automatic instr_t mk(logic [1:0] op, logic [RF_AW-1:0] dst,
                                  logic [2:0] sa, logic [RF_AW-1:0] ra,
                                  logic [2:0] sb, logic [RF_AW-1:0] rb);
        instr_t r;
        r.op    = op;
        r.dst   = dst;
        r.sel_a = sa;
        r.ra    = ra;
        r.sel_b = sb;
        r.rb    = rb;
        return r;
    endfunction

    function automatic prog_t build_prog();
        prog_t            p;
        int               n;
        logic [RF_AW-1:0] b;
        logic [RF_AW-1:0] e;
        logic [2:0]       coef;
        n = 0;
        for (int st = 0; st < 4; st++)
        begin
            b = (st == 0) ? RA_X : RA_Y;
            // derivative of the point at b
            p[n] = mk(OP_SUB, RA_T, SRC_ONE, RA_T, SRC_RF, b);        n++;
            p[n] = mk(OP_SUB, RA_T, SRC_RF, RA_T, SRC_RF, b + 5'd1);  n++;
            p[n] = mk(OP_SUB, RA_T, SRC_RF, RA_T, SRC_QTR, RA_T);     n++;
            p[n] = mk(OP_SUB, RA_U, SRC_ONE, RA_U, SRC_RF, b + 5'd2); n++;
            p[n] = mk(OP_SUB, RA_U, SRC_RF, RA_U, SRC_RF, b + 5'd3);  n++;
            p[n] = mk(OP_MUL, RA_P, SRC_RF, b, SRC_RF, b + 5'd2);     n++;
            p[n] = mk(OP_MUL, RA_K, SRC_RF, RA_P, SRC_RF, RA_T);      n++;
            p[n] = mk(OP_ADD, RA_P, SRC_RF, b + 5'd1, SRC_RF, b + 5'd1); n++;
            p[n] = mk(OP_MUL, RA_P, SRC_RF, RA_P, SRC_RF, b + 5'd2);  n++;
            p[n] = mk(OP_MUL, RA_K + 5'd1, SRC_RF, RA_P, SRC_RF, RA_T); n++;
            p[n] = mk(OP_ADD, RA_P, SRC_RF, b, SRC_RF, b);            n++;
            p[n] = mk(OP_MUL, RA_P, SRC_RF, RA_P, SRC_RF, RA_U);      n++;
            p[n] = mk(OP_MUL, RA_Q, SRC_QTR, RA_Q, SRC_RF, b + 5'd2); n++;
            p[n] = mk(OP_SUB, RA_K + 5'd2, SRC_RF, RA_P, SRC_RF, RA_Q); n++;
            p[n] = mk(OP_MUL, RA_P, SRC_RF, b + 5'd1, SRC_RF, RA_U);  n++;
            p[n] = mk(OP_MUL, RA_Q, SRC_QTR, RA_Q, SRC_RF, b + 5'd3); n++;
            p[n] = mk(OP_SUB, RA_K + 5'd3, SRC_RF, RA_P, SRC_RF, RA_Q); n++;
            coef = (st == 1) ? SRC_HH : SRC_H;
            for (int i = 0; i < NUM_EQ; i++)
            begin
                e = 5'(i);
                if (st == 0)
                begin
                    p[n] = mk(OP_ADD, RA_S + e, SRC_RF, RA_K + e, SRC_ZERO, RA_K); n++;
                    p[n] = mk(OP_MUL, RA_P, SRC_HH, RA_P, SRC_RF, RA_K + e);      n++;
                    p[n] = mk(OP_ADD, RA_Y + e, SRC_RF, RA_X + e, SRC_RF, RA_P);  n++;
                end
                else if (st < 3)
                begin
                    p[n] = mk(OP_ADD, RA_P, SRC_RF, RA_K + e, SRC_RF, RA_K + e);  n++;
                    p[n] = mk(OP_ADD, RA_S + e, SRC_RF, RA_S + e, SRC_RF, RA_P);  n++;
                    p[n] = mk(OP_MUL, RA_P, coef, RA_P, SRC_RF, RA_K + e);        n++;
                    p[n] = mk(OP_ADD, RA_Y + e, SRC_RF, RA_X + e, SRC_RF, RA_P);  n++;
                end
                else
                begin
                    p[n] = mk(OP_ADD, RA_S + e, SRC_RF, RA_S + e, SRC_RF, RA_K + e); n++;
                    p[n] = mk(OP_MUL, RA_P, SRC_H, RA_P, SRC_RF, RA_S + e);        n++;
                    p[n] = mk(OP_DIV6, RA_P, SRC_RF, RA_P, SRC_ZERO, RA_P);        n++;
                    p[n] = mk(OP_ADD, RA_X + e, SRC_RF, RA_X + e, SRC_RF, RA_P);   n++;
                end
            end
        end
        return p;
    endfunction

    localparam prog_t PROG = build_prog();

endpackage

@@ hw/rtl/rk4_if.sv @@
interface rk4_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] load_a;
    logic signed [31:0] load_b;
    logic signed [31:0] load_c;
    logic signed [31:0] load_d;

    modport source (output valid, action, load_a, load_b, load_c, load_d, input ready);
    modport sink (input valid, action, load_a, load_b, load_c, load_d, output ready);
endinterface

interface rk4_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        step_index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic               overflow;

    modport source (output valid, step_index, value_a, value_b, value_c, value_d, overflow,
                    input ready);
    modport sink (input valid, step_index, value_a, value_b, value_c, value_d, overflow,
                  output ready);
endinterface

@@ hw/rtl/rk4_four_equation_ode_step_unit.sv @@
// a step runs 128 micro-ops on one shared alu, each in a register read state then an execute state
// throughput: one word at a time, next word accepted once the previous result is queued
// reset: state and step counter read zero, step size returns to 1678, no result pending
// after reset the state registers are cleared before the first word is accepted
module rk4_four_equation_ode_step_unit #(
    parameter int FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [24:0] cfg_wdata,
    rk4_in_if.sink      cmd,
    rk4_out_if.source   res
);
    import rk4_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EX   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_INIT = 3'd5;

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] QTR_FX = ONE_FX >>> 2;

    logic [2:0]         state_reg, state_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [15:0]        steps_reg, steps_next;
    logic               ovf_reg, ovf_next;
    logic [24:0]        step_size_reg;
    logic signed [31:0] shadow_reg [NUM_EQ];
    logic signed [31:0] shadow_next [NUM_EQ];
    logic               res_valid_reg, res_valid_next;
    logic [15:0]        res_idx_reg, res_idx_next;
    logic signed [31:0] res_val_reg [NUM_EQ];
    logic signed [31:0] res_val_next [NUM_EQ];
    logic               res_ovf_reg, res_ovf_next;

    instr_t             ins;
    logic               rf_we;
    logic [RF_AW-1:0]   rf_waddr;
    logic signed [31:0] rf_wdata;
    logic signed [31:0] rd_a, rd_b;
    logic signed [31:0] opa, opb;
    logic signed [31:0] alu_y;
    logic               alu_ovf;
    logic signed [31:0] h_fx, hh_fx;

    assign ins   = PROG[pc_reg];
    assign h_fx  = {7'd0, step_size_reg};
    assign hh_fx = {8'd0, step_size_reg[24:1]};

    rk4_rf u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (ins.ra),
        .raddr_b (ins.rb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        unique case (ins.sel_a)
            SRC_ONE:  opa = ONE_FX;
            SRC_QTR:  opa = QTR_FX;
            SRC_H:    opa = h_fx;
            SRC_HH:   opa = hh_fx;
            SRC_ZERO: opa = '0;
            default:  opa = rd_a;
        endcase
        unique case (ins.sel_b)
            SRC_ONE:  opb = ONE_FX;
            SRC_QTR:  opb = QTR_FX;
            SRC_H:    opb = h_fx;
            SRC_HH:   opb = hh_fx;
            SRC_ZERO: opb = '0;
            default:  opb = rd_b;
        endcase
    end

    rk4_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .op  (ins.op),
        .a   (opa),
        .b   (opb),
        .y   (alu_y),
        .ovf (alu_ovf)
    );

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        steps_next     = steps_reg;
        ovf_next       = ovf_reg;
        shadow_next    = shadow_reg;
        res_valid_next = res_valid_reg;
        res_idx_next   = res_idx_reg;
        res_val_next   = res_val_reg;
        res_ovf_next   = res_ovf_reg;
        rf_we          = 1'b0;
        rf_waddr       = ins.dst;
        rf_wdata       = alu_y;
        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    ovf_next = 1'b0;
                    if (cmd.action == ACT_LOAD)
                    begin
                        shadow_next[0] = cmd.load_a;
                        shadow_next[1] = cmd.load_b;
                        shadow_next[2] = cmd.load_c;
                        shadow_next[3] = cmd.load_d;
                        steps_next     = '0;
                        cnt_next       = '0;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        pc_next    = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_LOAD, ST_INIT:
            begin
                rf_we    = 1'b1;
                rf_waddr = RF_AW'(cnt_reg);
                rf_wdata = shadow_reg[cnt_reg];
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'(NUM_EQ - 1))
                    state_next = (state_reg == ST_LOAD) ? ST_DONE : ST_IDLE;
            end
            ST_RD:
                state_next = ST_EX;
            ST_EX:
            begin
                rf_we = 1'b1;
                if (alu_ovf)
                    ovf_next = 1'b1;
                if (ins.dst < RA_Y)
                    shadow_next[ins.dst[1:0]] = alu_y;
                if (pc_reg == PC_W'(PROG_LEN - 1))
                begin
                    steps_next = steps_reg + 16'd1;
                    state_next = ST_DONE;
                end
                else
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_idx_next   = steps_reg;
                    res_val_next   = shadow_reg;
                    res_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            steps_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            step_size_reg <= STEP_RESET;
            for (int i = 0; i < NUM_EQ; i++)
            begin
                shadow_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            steps_reg     <= steps_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
            shadow_reg    <= shadow_next;
            if (cfg_we)
                step_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        res_idx_reg <= res_idx_next;
        res_val_reg <= res_val_next;
        res_ovf_reg <= res_ovf_next;
    end

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign res.valid      = res_valid_reg;
    assign res.step_index = res_idx_reg;
    assign res.value_a    = res_val_reg[0];
    assign res.value_b    = res_val_reg[1];
    assign res.value_c    = res_val_reg[2];
    assign res.value_d    = res_val_reg[3];
    assign res.overflow   = res_ovf_reg;

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside completion");

    a_prog_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EX && pc_reg == PC_W'(PROG_LEN - 1)) |=> state_reg == ST_DONE)
        else $error("step program did not finish");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.action == ACT_LOAD) |=> (steps_reg == '0 && !ovf_reg))
        else $error("load did not clear counter and flag");

    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.action != ACT_LOAD) |=> (pc_reg == '0 && !ovf_reg))
        else $error("step did not start at program head");
endmodule

@@ hw/rtl/rk4_alu.sv @@
module rk4_alu #(
    parameter int FRAC_BITS = 24
) (
    input  logic [1:0]         op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] y,
    output logic               ovf
);
    import rk4_pkg::*;

    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [32:0] sum_w;
    logic signed [63:0] prod;
    logic signed [63:0] prod_r;
    logic signed [63:0] shifted;
    logic [32:0]        mag;
    logic [32:0]        num;
    logic [64:0]        qprod;
    logic [30:0]        quo;

    always_comb
    begin
        sum_w   = (op == OP_SUB) ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        prod    = a * b;
        prod_r  = prod + ROUND_HALF;
        shifted = prod_r >>> FRAC_BITS;
        mag     = a[31] ? (33'd0 - {a[31], a}) : {1'b0, a};
        num     = mag + 33'd3;
        qprod   = 65'(num) * 65'(DIV6_RECIP);
        quo     = qprod[DIV6_SHIFT +: 31];
        y       = '0;
        ovf     = 1'b0;
        unique case (op)
            OP_ADD, OP_SUB:
            begin
                if (sum_w > 33'sh0_7FFF_FFFF)
                begin
                    y   = 32'sh7FFF_FFFF;
                    ovf = 1'b1;
                end
                else if (sum_w < -33'sh0_8000_0000)
                begin
                    y   = 32'sh8000_0000;
                    ovf = 1'b1;
                end
                else
                    y = sum_w[31:0];
            end
            OP_MUL:
            begin
                if (shifted > 64'sh7FFF_FFFF)
                begin
                    y   = 32'sh7FFF_FFFF;
                    ovf = 1'b1;
                end
                else if (shifted < -64'sh8000_0000)
                begin
                    y   = 32'sh8000_0000;
                    ovf = 1'b1;
                end
                else
                    y = shifted[31:0];
            end
            OP_DIV6:
                y = a[31] ? (32'sd0 - {1'b0, quo}) : {1'b0, quo};
            default:
                y = '0;
        endcase
    end
endmodule

@@ hw/rtl/rk4_rf.sv @@
module rk4_rf (
    input  logic                         clk,
    input  logic                         we,
    input  logic [rk4_pkg::RF_AW-1:0]    waddr,
    input  logic signed [31:0]           wdata,
    input  logic [rk4_pkg::RF_AW-1:0]    raddr_a,
    input  logic [rk4_pkg::RF_AW-1:0]    raddr_b,
    output logic signed [31:0]           rdata_a,
    output logic signed [31:0]           rdata_b
);
    import rk4_pkg::*;

    logic signed [31:0] mem [RF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

@@ tb/tb_rk4_four_equation_ode_step_unit.sv @@
`timescale 1ns / 100ps

module tb_rk4_four_equation_ode_step_unit;

    import rk4_pkg::*;

    typedef logic signed [31:0] fx_t;
    typedef fx_t vec_t [4];

    typedef struct {
        logic        act;
        fx_t         a, b, c, d;
        bit          typed;
        logic [15:0] idx;
        fx_t         ea, eb, ec, ed;
        logic        eo;
    } dir_row_t;

    typedef struct {
        logic [15:0] idx;
        fx_t         a, b, c, d;
        logic        ovf;
    } ode_res_t;

    localparam logic   ACT_STEP    = ~ACT_LOAD;
    localparam fx_t    FX_ONE      = 32'sh0100_0000;
    localparam fx_t    FX_QTR      = 32'sh0040_0000;
    localparam fx_t    FX_MAX      = 32'sh7fff_ffff;
    localparam fx_t    FX_MIN      = 32'sh8000_0000;
    localparam int     CYCLE_LIMIT = 3_000_000;
    localparam int     PHASE_WORDS = 200;
    localparam int     HOLD_CYCLES = 3000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [24:0] cfg_wdata;

    rk4_in_if  cmd_if ();
    rk4_out_if res_if ();

    rk4_four_equation_ode_step_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // integrator state as the block should hold it
    vec_t        ode_x;
    logic [15:0] ode_steps;
    logic [24:0] ode_h;
    bit          ode_ovf;

    ode_res_t    expected_q[$];
    int          errors;
    int          send_idle;
    int          recv_stall;
    bit          hold_req;
    int          hold_cnt;
    longint      cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic fx_t sat32(longint v);
        if (v > longint'(FX_MAX))
        begin
            ode_ovf = 1'b1;
            return FX_MAX;
        end
        if (v < longint'(FX_MIN))
        begin
            ode_ovf = 1'b1;
            return FX_MIN;
        end
        return fx_t'(v);
    endfunction

    function automatic fx_t q_add(fx_t p, fx_t q);
        return sat32(longint'(p) + longint'(q));
    endfunction

    function automatic fx_t q_sub(fx_t p, fx_t q);
        return sat32(longint'(p) - longint'(q));
    endfunction

    function automatic fx_t q_mul(fx_t p, fx_t q);
        longint prod;
        prod = longint'(p) * longint'(q) + (longint'(1) << 23);
        return sat32(prod >>> 24);
    endfunction

    function automatic fx_t q_div6(fx_t v);
        longint m;
        longint q;
        m = (v < 0) ? -longint'(v) : longint'(v);
        q = (m + 3) / 6;
        return fx_t'((v < 0) ? -q : q);
    endfunction

    function automatic vec_t rates(vec_t x);
        vec_t f;
        fx_t  t;
        fx_t  u;
        t = q_sub(q_sub(q_sub(FX_ONE, x[0]), x[1]), FX_QTR);
        u = q_sub(q_sub(FX_ONE, x[2]), x[3]);
        f[0] = q_mul(q_mul(x[0], x[2]), t);
        f[1] = q_mul(q_mul(q_add(x[1], x[1]), x[2]), t);
        f[2] = q_sub(q_mul(q_add(x[0], x[0]), u), q_mul(FX_QTR, x[2]));
        f[3] = q_sub(q_mul(x[1], u), q_mul(FX_QTR, x[3]));
        return f;
    endfunction

    function automatic ode_res_t integrate_word(logic act, fx_t a, fx_t b, fx_t c, fx_t d);
        vec_t     k1, k2, k3, k4, y;
        fx_t      h;
        fx_t      hh;
        fx_t      s;
        ode_res_t r;
        ode_ovf = 1'b0;
        if (act == ACT_LOAD)
        begin
            ode_x     = '{a, b, c, d};
            ode_steps = '0;
        end
        else
        begin
            h  = fx_t'({7'b0, ode_h});
            hh = fx_t'({8'b0, ode_h[24:1]});
            k1 = rates(ode_x);
            for (int i = 0; i < 4; i++) y[i] = q_add(ode_x[i], q_mul(hh, k1[i]));
            k2 = rates(y);
            for (int i = 0; i < 4; i++) y[i] = q_add(ode_x[i], q_mul(hh, k2[i]));
            k3 = rates(y);
            for (int i = 0; i < 4; i++) y[i] = q_add(ode_x[i], q_mul(h, k3[i]));
            k4 = rates(y);
            for (int i = 0; i < 4; i++)
            begin
                s = q_add(q_add(q_add(k1[i], q_add(k2[i], k2[i])), q_add(k3[i], k3[i])),
                          k4[i]);
                ode_x[i] = q_add(ode_x[i], q_div6(q_mul(h, s)));
            end
            ode_steps = ode_steps + 16'd1;
        end
        r.idx = ode_steps;
        r.a   = ode_x[0];
        r.b   = ode_x[1];
        r.c   = ode_x[2];
        r.d   = ode_x[3];
        r.ovf = ode_ovf;
        return r;
    endfunction

    task automatic send_word(logic act, fx_t a, fx_t b, fx_t c, fx_t d, bit typed,
                             ode_res_t typed_res);
        ode_res_t r;
        while ($urandom_range(99) < send_idle)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.action <= act;
        cmd_if.load_a <= a;
        cmd_if.load_b <= b;
        cmd_if.load_c <= c;
        cmd_if.load_d <= d;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        r = integrate_word(act, a, b, c, d);
        expected_q.push_back(typed ? typed_res : r);
    endtask

    task automatic write_step_size(logic [24:0] v);
        cmd_if.valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ode_h = v;
    endtask

    function automatic fx_t rand_load();
        if ($urandom_range(99) < 20)
            return fx_t'($urandom);
        return fx_t'(int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
    endfunction

    task automatic run_phase(logic [24:0] h, int idle, int stall, bit squeeze);
        ode_res_t none;
        none = '{default: '0};
        write_step_size(h);
        send_idle  = idle;
        recv_stall = stall;
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            if (squeeze && n == 40)
                hold_req = 1'b1;
            if ($urandom_range(99) < 15)
                send_word(ACT_LOAD, rand_load(), rand_load(), rand_load(), rand_load(), 0, none);
            else
                send_word(ACT_STEP, fx_t'($urandom), fx_t'($urandom), fx_t'($urandom),
                          fx_t'($urandom), 0, none);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) < recv_stall) ? 1'b0 : 1'b1;
    end

    always @(posedge clk)
    begin
        ode_res_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: step_index %0d", res_if.step_index);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_if.step_index !== e.idx)
                begin
                    $error("step_index: expected %0d, got %0d", e.idx, res_if.step_index);
                    errors++;
                end
                if (res_if.value_a !== e.a)
                begin
                    $error("value_a: expected %h, got %h", e.a, res_if.value_a);
                    errors++;
                end
                if (res_if.value_b !== e.b)
                begin
                    $error("value_b: expected %h, got %h", e.b, res_if.value_b);
                    errors++;
                end
                if (res_if.value_c !== e.c)
                begin
                    $error("value_c: expected %h, got %h", e.c, res_if.value_c);
                    errors++;
                end
                if (res_if.value_d !== e.d)
                begin
                    $error("value_d: expected %h, got %h", e.d, res_if.value_d);
                    errors++;
                end
                if (res_if.overflow !== e.ovf)
                begin
                    $error("overflow: expected %b, got %b", e.ovf, res_if.overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    dir_row_t dir_tab [14] = '{
        '{ACT_STEP, 0, 0, 0, 0, 1, 16'd1, 0, 0, 0, 0, 1'b0},
        '{ACT_LOAD, 0, 0, 0, 0, 1, 16'd0, 0, 0, 0, 0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 1, 16'd1, 0, 0, 0, 0, 1'b0},
        '{ACT_LOAD, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1, 16'd0,
          FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1, 16'd0,
          FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0},
        '{ACT_STEP, FX_MAX, FX_MIN, FX_MAX, FX_MIN, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, FX_MAX, FX_MIN, FX_MIN, FX_MAX, 1, 16'd0,
          FX_MAX, FX_MIN, FX_MIN, FX_MAX, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 1,
          16'd0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, FX_QTR, FX_QTR, FX_ONE, FX_QTR, 1, 16'd0,
          FX_QTR, FX_QTR, FX_ONE, FX_QTR, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_STEP, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0}
    };

    initial
    begin
        ode_res_t tr;
        cmd_if.valid  = 1'b0;
        cmd_if.action = ACT_LOAD;
        cmd_if.load_a = '0;
        cmd_if.load_b = '0;
        cmd_if.load_c = '0;
        cmd_if.load_d = '0;
        res_if.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        errors        = 0;
        send_idle     = 0;
        recv_stall    = 0;
        hold_req      = 1'b0;
        hold_cnt      = 0;
        cycles        = 0;
        ode_x         = '{0, 0, 0, 0};
        ode_steps     = '0;
        ode_h         = STEP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            tr = '{dir_tab[i].idx, dir_tab[i].ea, dir_tab[i].eb, dir_tab[i].ec,
                   dir_tab[i].ed, dir_tab[i].eo};
            send_word(dir_tab[i].act, dir_tab[i].a, dir_tab[i].b, dir_tab[i].c,
                      dir_tab[i].d, dir_tab[i].typed, tr);
        end

        run_phase(25'd16777216, 0, 0, 1);
        run_phase(25'd0, 51, 0, 0);
        run_phase(25'h1ff_ffff, 0, 51, 0);
        run_phase(25'($urandom_range(200000, 1000)), 31, 31, 0);
        run_phase(STEP_RESET, 31, 31, 0);

        cmd_if.valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rk4_pkg.sv
hw/rtl/rk4_if.sv
hw/rtl/rk4_alu.sv
hw/rtl/rk4_rf.sv
hw/rtl/rk4_four_equation_ode_step_unit.sv
tb/tb_rk4_four_equation_ode_step_unit.sv
